@@ rtl/rgse_pkg.sv @@
// ----------------------------------------------------------------------------
// rgse_pkg - shared types and constants for the RGB gray Sobel edge stream
// Item layouts, register indexes, reset values and the gray conversion.
// ----------------------------------------------------------------------------
package rgse_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 12;
  localparam int CFG_DATA_W     = 12;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [7:0] COEF_BLUE  = 8'd29;
  localparam logic [7:0] COEF_GREEN = 8'd150;
  localparam logic [7:0] COEF_RED   = 8'd77;
  localparam logic [7:0] EDGE_MAX   = 8'd255;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0]  edge_value;
    logic [11:0] center_row;
    logic [9:0]  center_col;
    logic        frame_last;
  } result_item_t;

  // weighted channel sum, each term truncated separately; never exceeds 253
  function automatic logic [7:0] gray_of(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
    logic [15:0] pb;
    logic [15:0] pg;
    logic [15:0] pr;
    logic [9:0]  s;
    pb = b * COEF_BLUE;
    pg = g * COEF_GREEN;
    pr = r * COEF_RED;
    s  = 10'(pb[15:8]) + 10'(pg[15:8]) + 10'(pr[15:8]);
    return s[7:0];
  endfunction

endpackage

@@ rtl/rgse_line_store.sv @@
// ----------------------------------------------------------------------------
// rgse_line_store - two gray line stores with registered read
// One read and one write per cycle on each store; a read that meets a write
// to the same column in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module rgse_line_store
  import rgse_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_upper,
  input  logic [7:0]    wr_middle,
  output logic [7:0]    upper,
  output logic [7:0]    middle
);

  logic [7:0] mem_upper  [MAX_WIDTH];
  logic [7:0] mem_middle [MAX_WIDTH];

  logic [7:0] upper_q;
  logic [7:0] middle_q;
  logic       fwd;
  logic [7:0] fwd_upper;
  logic [7:0] fwd_middle;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr]  <= wr_upper;
      mem_middle[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      upper_q  <= mem_upper[rd_addr];
      middle_q <= mem_middle[rd_addr];
    end
  end

  // bypass for read-during-write on the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_upper  <= wr_upper;
      fwd_middle <= wr_middle;
    end
  end

  assign upper  = fwd ? fwd_upper  : upper_q;
  assign middle = fwd ? fwd_middle : middle_q;

endmodule

@@ rtl/rgb_gray_sobel_edge_stream_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_stream_unit - streaming 3x3 Sobel edge magnitude
// Converts raster RGB pixels to gray and emits |Gx|+|Gy| for interior pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pixel_stall is low and gives at most one result
// per pixel; a result passes through stage 1 and then the output register. The
// rate is set by the line stores: two MAX_WIDTH x 8 memories, each read and
// written once per pixel at the current column, with a bypass when the same
// column is read and written in one cycle. Only pixels whose centre lies in
// rows 1..H-2 and columns 1..W-2 produce a result; frame_last marks the last
// one of a frame. Counters follow frame_start, and also wrap on their own at
// the end of a frame. Line store contents are undefined after reset and need
// no clearing pass: every entry is written before it is used in a frame.
// frame_width and frame_height should be written while the block is idle.
module rgb_gray_sobel_edge_stream_unit
  import rgse_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_item_t            pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_item_t           result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = ((MW_W > FRAME_WIDTH_W) ? MW_W : FRAME_WIDTH_W) + 1;

  // configuration
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMP_W-1:0]          width_eff;
  logic [FRAME_HEIGHT_W:0]   height_eff;

  always_comb begin
    width_eff = CMP_W'(frame_width);
    if (width_eff < CMP_W'(3)) width_eff = CMP_W'(3);
    if (width_eff > CMP_W'(MAX_WIDTH)) width_eff = CMP_W'(MAX_WIDTH);
    height_eff = (FRAME_HEIGHT_W+1)'(frame_height);
    if (height_eff < (FRAME_HEIGHT_W+1)'(3)) height_eff = (FRAME_HEIGHT_W+1)'(3);
  end

  // handshake
  logic s1_valid;
  logic s1_emit;
  logic s1_go;
  logic accept;

  assign s1_go       = s1_valid && (!s1_emit || !result_valid || !result_stall);
  assign pixel_stall = s1_valid && !s1_go;
  assign accept      = pixel_valid && !pixel_stall;

  // position counters
  logic [AW-1:0]             column_count;
  logic [FRAME_HEIGHT_W-1:0] row_count;
  logic [AW-1:0]             col;
  logic [FRAME_HEIGHT_W-1:0] row;
  logic                      col_end;
  logic                      row_end;
  logic [AW-1:0]             column_count_next;
  logic [FRAME_HEIGHT_W-1:0] row_count_next;

  always_comb begin
    col     = pixel.frame_start ? '0 : column_count;
    row     = pixel.frame_start ? '0 : row_count;
    col_end = (CMP_W'(col) + CMP_W'(1)) >= width_eff;
    row_end = ((FRAME_HEIGHT_W+1)'(row) + (FRAME_HEIGHT_W+1)'(1)) >= height_eff;
    if (col_end) begin
      column_count_next = '0;
      row_count_next    = row_end ? '0 : row + FRAME_HEIGHT_W'(1);
    end else begin
      column_count_next = col + AW'(1);
      row_count_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // stage 1: line store read in flight, gray and position held
  logic [7:0]                s1_gray;
  logic [AW-1:0]             s1_cidx;
  logic [FRAME_HEIGHT_W-1:0] s1_row_m1;
  logic [AW-1:0]             s1_col_m1;
  logic                      s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray   <= gray_of(pixel.blue, pixel.green, pixel.red);
      s1_cidx   <= col;
      s1_emit   <= (row >= FRAME_HEIGHT_W'(2)) && (col >= AW'(2));
      s1_row_m1 <= row - FRAME_HEIGHT_W'(1);
      s1_col_m1 <= col - AW'(1);
      s1_last   <= row_end && col_end;
    end
  end

  logic [7:0] up_new;
  logic [7:0] mid_new;

  rgse_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (col),
    .wr_en     (s1_go),
    .wr_addr   (s1_cidx),
    .wr_upper  (mid_new),
    .wr_middle (s1_gray),
    .upper     (up_new),
    .middle    (mid_new)
  );

  // window: columns col-2 and col-1, rows upper/middle/lower
  logic [7:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (s1_go) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= up_new;
      win[4] <= mid_new;
      win[5] <= s1_gray;
    end
  end

  // gradient magnitude
  logic [9:0]  gx_top;
  logic [9:0]  gx_bot;
  logic [9:0]  gy_left;
  logic [9:0]  gy_right;
  logic [9:0]  abs_gx;
  logic [9:0]  abs_gy;
  logic [10:0] mag;
  logic [7:0]  edge_sat;

  always_comb begin
    gx_top   = 10'(win[0]) + {1'b0, win[3], 1'b0} + 10'(up_new);
    gx_bot   = 10'(win[2]) + {1'b0, win[5], 1'b0} + 10'(s1_gray);
    gy_left  = 10'(win[0]) + {1'b0, win[1], 1'b0} + 10'(win[2]);
    gy_right = 10'(up_new) + {1'b0, mid_new, 1'b0} + 10'(s1_gray);
    abs_gx   = (gx_top >= gx_bot) ? gx_top - gx_bot : gx_bot - gx_top;
    abs_gy   = (gy_left >= gy_right) ? gy_left - gy_right : gy_right - gy_left;
    mag      = 11'(abs_gx) + 11'(abs_gy);
    edge_sat = (mag > 11'(EDGE_MAX)) ? EDGE_MAX : mag[7:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      result.edge_value <= edge_sat;
      result.center_row <= s1_row_m1;
      result.center_col <= 10'(s1_col_m1);
      result.frame_last <= s1_last;
    end
  end

endmodule
